// ===== sv/hdc_pkg.sv =====
// Package for the heading turn direction classifier.
// Holds the window sizes, the direction codes, the status struct and the
// delta wrapping and sum saturation functions. Depends on nothing.
`default_nettype none

package hdc_pkg;

   // Number of yaw samples in a full window; the ring holds one fewer delta.
   localparam int HISTORY_DEPTH = 8;
   localparam int RING_LEN      = HISTORY_DEPTH - 1;

   // Field widths.
   localparam int YAW_W        = 16;
   localparam int THRESHOLD_W  = 15;
   localparam int WINDOW_SUM_W = 18;
   localparam int DIR_W        = 2;

   // Internal widths, derived from the window depth and the field widths, and the delta wrap limits.
   localparam int PTR_W  = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;
   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam int DELTA_LIMIT = 18000;
   localparam int DELTA_SPAN  = 36000;
   localparam int SUM_W  = $clog2(DELTA_LIMIT * RING_LEN + 1) + 1;
   localparam int EXT_W  = (SUM_W > WINDOW_SUM_W) ? SUM_W : WINDOW_SUM_W;
   localparam int LIM_W  = THRESHOLD_W + $clog2(RING_LEN + 1);
   localparam int CMP_W  = ((SUM_W > LIM_W + 1) ? SUM_W : LIM_W + 1) + 1;
   localparam int RAW_W  = YAW_W + 1;

   // Reset value of the threshold register.
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = THRESHOLD_W'(100);

   // Saturation limits of the reported window sum.
   localparam int WINDOW_SUM_MAX = (1 << (WINDOW_SUM_W - 1)) - 1;
   localparam int WINDOW_SUM_MIN = -(1 << (WINDOW_SUM_W - 1));

   // Direction codes.
   typedef enum logic [DIR_W-1:0] {
      DIR_STRAIGHT = 2'd0,
      DIR_LEFT     = 2'd1,
      DIR_RIGHT    = 2'd2
   } dir_type;

   // Window state as seen after the current sample has been folded in.
   typedef struct packed {
      logic                    full;
      logic signed [SUM_W-1:0] sum;
   } window_status_type;

   // Wrap a raw yaw difference into -18000..+18000. The raw difference of two
   // 16-bit samples needs at most two correction steps.
   function automatic logic signed [YAW_W-1:0] wrap_delta(
      input logic signed [RAW_W-1:0] raw
   );
      logic signed [RAW_W-1:0] d;
      d = raw;
      for (int i = 0; i < 2; i++) begin
         if (d > RAW_W'(DELTA_LIMIT)) begin
            d = d - RAW_W'(DELTA_SPAN);
         end else if (d < -RAW_W'(DELTA_LIMIT)) begin
            d = d + RAW_W'(DELTA_SPAN);
         end
      end
      return d[YAW_W-1:0];
   endfunction

   // Clamp the exact window sum to the reported field width.
   function automatic logic signed [WINDOW_SUM_W-1:0] saturate_sum(
      input logic signed [SUM_W-1:0] s
   );
      logic signed [EXT_W-1:0] e;
      e = EXT_W'(s);
      if (e > EXT_W'(WINDOW_SUM_MAX)) begin
         e = EXT_W'(WINDOW_SUM_MAX);
      end else if (e < EXT_W'(WINDOW_SUM_MIN)) begin
         e = EXT_W'(WINDOW_SUM_MIN);
      end
      return e[WINDOW_SUM_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/heading_turn_direction_classifier.sv =====
// Heading turn direction classifier: an accepted request waits in the input
// register until the result register is free, then goes through the window
// update into the result register, which offers its response. Throughput is
// one transaction per cycle without response stalls; the input register takes
// one more request while a response waits. Reset clears the yaw history,
// the ring, the sum and the sample count, and sets the turn threshold to 100.
`default_nettype none

module heading_turn_direction_classifier (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_valid,
   output      logic                                       req_stall,
   input  wire logic signed [hdc_pkg::YAW_W-1:0]           req_yaw,
   output      logic                                       rsp_valid,
   input  wire logic                                       rsp_stall,
   output      logic                                       rsp_decided,
   output      logic [hdc_pkg::DIR_W-1:0]                  rsp_direction,
   output      logic signed [hdc_pkg::WINDOW_SUM_W-1:0]    rsp_window_sum,
   input  wire logic                                       csr_valid,
   output      logic                                       csr_ready,
   input  wire logic [hdc_pkg::THRESHOLD_W-1:0]            csr_data
);

   logic [hdc_pkg::THRESHOLD_W-1:0]         threshold_ff;
   logic                                    in_valid_ff;
   logic                                    in_valid_in;
   logic signed [hdc_pkg::YAW_W-1:0]        in_yaw_ff;
   logic                                    out_valid_ff;
   logic                                    out_valid_in;
   logic                                    out_decided_ff;
   hdc_pkg::dir_type                        out_dir_ff;
   logic signed [hdc_pkg::WINDOW_SUM_W-1:0] out_sum_ff;
   logic                                    req_accept;
   logic                                    advance;
   hdc_pkg::window_status_type              status;
   logic [hdc_pkg::LIM_W-1:0]               limit;
   logic signed [hdc_pkg::CMP_W-1:0]        limit_cmp;
   logic signed [hdc_pkg::CMP_W-1:0]        sum_cmp;
   hdc_pkg::dir_type                        dir;

   // Handshake: the input register moves on when the result register is free.
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && out_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= hdc_pkg::THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_yaw_ff <= req_yaw;
      end
   end

   // Delta history window.
   hdc_window u_window (
      .clock  (clock),
      .reset  (reset),
      .update (advance),
      .yaw    (in_yaw_ff),
      .status (status)
   );

   // Compare the exact sum with threshold times the number of deltas.
   assign limit     = hdc_pkg::LIM_W'(threshold_ff) * hdc_pkg::LIM_W'(hdc_pkg::RING_LEN);
   assign limit_cmp = hdc_pkg::CMP_W'(limit);
   assign sum_cmp   = hdc_pkg::CMP_W'(status.sum);

   always_comb begin
      priority if (sum_cmp > limit_cmp) begin
         dir = hdc_pkg::DIR_LEFT;
      end else if (sum_cmp < -limit_cmp) begin
         dir = hdc_pkg::DIR_RIGHT;
      end else begin
         dir = hdc_pkg::DIR_STRAIGHT;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_decided_ff <= status.full;
         out_dir_ff     <= status.full ? dir : hdc_pkg::DIR_STRAIGHT;
         out_sum_ff     <= status.full ? hdc_pkg::saturate_sum(status.sum) : '0;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_decided    = out_decided_ff;
   assign rsp_direction  = out_dir_ff;
   assign rsp_window_sum = out_sum_ff;

   // An undecided response carries no direction and no sum.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_decided) |-> (rsp_direction == hdc_pkg::DIR_STRAIGHT
         && rsp_window_sum == '0))
      else $error("undecided response carries a direction or a sum");

   // A left turn needs a positive sum and a right turn a negative one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_direction == hdc_pkg::DIR_LEFT) |-> (rsp_window_sum > 0))
      else $error("left turn reported with a sum that is not positive");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_direction == hdc_pkg::DIR_RIGHT) |-> (rsp_window_sum < 0))
      else $error("right turn reported with a sum that is not negative");

   // A held request that is free to move must show up as a response.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !(out_valid_ff && rsp_stall)) |=> out_valid_ff)
      else $error("transaction lost between input and result registers");

endmodule

`default_nettype wire

// ===== sv/hdc_window.sv =====
// Delta history window of the heading turn direction classifier.
// Keeps the previous yaw, the ring of wrapped deltas, their running sum and
// the sample count. Depends on hdc_pkg.
`default_nettype none

module hdc_window (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                update,
   input  wire logic signed [hdc_pkg::YAW_W-1:0]    yaw,
   output hdc_pkg::window_status_type               status
);

   logic signed [hdc_pkg::YAW_W-1:0] last_yaw_ff;
   logic signed [hdc_pkg::YAW_W-1:0] ring_ff [hdc_pkg::RING_LEN];
   logic signed [hdc_pkg::SUM_W-1:0] sum_ff;
   logic signed [hdc_pkg::SUM_W-1:0] sum_in;
   logic [hdc_pkg::PTR_W-1:0]        ptr_ff;
   logic [hdc_pkg::PTR_W-1:0]        ptr_in;
   logic [hdc_pkg::FILL_W-1:0]       fill_ff;
   logic [hdc_pkg::FILL_W-1:0]       fill_in;
   logic signed [hdc_pkg::YAW_W-1:0] delta;
   logic                             has_last;

   // A delta exists only once a previous sample has been stored.
   assign has_last = (fill_ff != '0);
   assign delta = hdc_pkg::wrap_delta(
      hdc_pkg::RAW_W'(yaw) - hdc_pkg::RAW_W'(last_yaw_ff));

   // Running sum, ring pointer and sample count for the current sample.
   always_comb begin
      sum_in  = sum_ff;
      ptr_in  = ptr_ff;
      fill_in = fill_ff;
      if (has_last) begin
         sum_in = sum_ff - hdc_pkg::SUM_W'(ring_ff[ptr_ff])
                  + hdc_pkg::SUM_W'(delta);
         if (ptr_ff == hdc_pkg::PTR_W'(hdc_pkg::RING_LEN - 1)) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + hdc_pkg::PTR_W'(1);
         end
      end
      if (fill_ff < hdc_pkg::FILL_W'(hdc_pkg::HISTORY_DEPTH)) begin
         fill_in = fill_ff + hdc_pkg::FILL_W'(1);
      end
   end

   // The status reflects the window with the current sample included.
   assign status.full = (fill_in >= hdc_pkg::FILL_W'(hdc_pkg::HISTORY_DEPTH));
   assign status.sum  = sum_in;

   // Window state registers, advanced once per processed transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_yaw_ff <= '0;
         sum_ff      <= '0;
         ptr_ff      <= '0;
         fill_ff     <= '0;
         for (int i = 0; i < hdc_pkg::RING_LEN; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (update) begin
         last_yaw_ff <= yaw;
         sum_ff      <= sum_in;
         ptr_ff      <= ptr_in;
         fill_ff     <= fill_in;
         if (has_last) begin
            ring_ff[ptr_ff] <= delta;
         end
      end
   end

endmodule

`default_nettype wire
